/* hdl/gsq_pkg.sv */
`timescale 1ns / 1ps

package gsq_pkg;

    localparam int QW     = 16;
    localparam int AW     = 16;
    localparam int GW     = 12;
    localparam int SW     = 63;
    localparam int NW     = 33;
    localparam int MAGW   = 33;
    localparam int NUMW   = MAGW + GW;
    localparam int REMW   = NUMW + 1;
    localparam int QUOW   = GW;
    localparam int BITS_PER_STEP = 3;
    localparam int STEPS  = QUOW / BITS_PER_STEP;
    localparam int CNTW   = $clog2(STEPS);
    localparam int LANES  = 3;
    localparam int FIFO_DEPTH = 2;

    localparam logic [GW-1:0] GRAV_RESET = 12'd2510;

    typedef struct packed {
        logic [LANES-1:0][NUMW-1:0]      num;
        logic [LANES-1:0]                neg;
        logic [NW-1:0]                   n;
        logic [LANES-1:0][AW-1:0]        accel;
        logic [SW-1:0]                   stamp;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } back_st_t;

endpackage

/* hdl/gravity_split_from_quaternion.sv */
`timescale 1ns / 1ps

// Splits an accelerometer sample into gravity and linear acceleration using an
// orientation quaternion (Q2.14); outputs are Q8.8, linear parts saturated.
// gravity is r * G / |q|^2 rounded half away from zero, G set through cfg_we /
// cfg_data (reset 9.80665). An all-zero quaternion gives zero gravity and
// zero_norm high. The back end runs a shared divider (12 quotient bits, 3 per
// cycle) and takes the next job only once the current result is loaded into the
// output registers. A 3-stage multiply front end and a 2-entry queue decouple
// input from the divider.
module gravity_split_from_quaternion (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [11:0]             cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [15:0]      quat_x,
    input  logic signed [15:0]      quat_y,
    input  logic signed [15:0]      quat_z,
    input  logic signed [15:0]      quat_w,
    input  logic signed [15:0]      accel_x,
    input  logic signed [15:0]      accel_y,
    input  logic signed [15:0]      accel_z,
    input  logic [62:0]             stamp_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [15:0]      linear_x,
    output logic signed [15:0]      linear_y,
    output logic signed [15:0]      linear_z,
    output logic signed [15:0]      gravity_x,
    output logic signed [15:0]      gravity_y,
    output logic signed [15:0]      gravity_z,
    output logic [62:0]             stamp_out,
    output logic                    zero_norm
);

    logic [gsq_pkg::GW-1:0] grav_mag_reg;
    logic                   f_valid, f_ready, b_valid, b_ready;
    gsq_pkg::job_t          f_job, b_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grav_mag_reg <= gsq_pkg::GRAV_RESET;
        else if (cfg_we)
            grav_mag_reg <= cfg_data;
    end

    gsq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .stamp_in  (stamp_in),
        .grav_mag  (grav_mag_reg),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    gsq_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_job),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_job)
    );

    gsq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .linear_x  (linear_x),
        .linear_y  (linear_y),
        .linear_z  (linear_z),
        .gravity_x (gravity_x),
        .gravity_y (gravity_y),
        .gravity_z (gravity_z),
        .stamp_out (stamp_out),
        .zero_norm (zero_norm)
    );

`ifndef ASSERT_OFF
    a_zero_grav: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_norm |-> gravity_x == 16'sd0 && gravity_y == 16'sd0
            && gravity_z == 16'sd0)
        else $error("zero norm with nonzero gravity");

    a_grav_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed(gravity_x) <= $signed({4'b0000, grav_mag_reg})
            && $signed(gravity_x) >= -$signed({4'b0000, grav_mag_reg}))
        else $error("gravity exceeds magnitude");

    a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_ready |-> !in_ready)
        else $error("front accepted while queue full");
`endif

endmodule

/* hdl/gsq_front.sv */
`timescale 1ns / 1ps

module gsq_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [15:0]            quat_x,
    input  logic signed [15:0]            quat_y,
    input  logic signed [15:0]            quat_z,
    input  logic signed [15:0]            quat_w,
    input  logic signed [15:0]            accel_x,
    input  logic signed [15:0]            accel_y,
    input  logic signed [15:0]            accel_z,
    input  logic [gsq_pkg::SW-1:0]        stamp_in,
    input  logic [gsq_pkg::GW-1:0]        grav_mag,
    output logic                          job_valid,
    input  logic                          job_ready,
    output gsq_pkg::job_t                 job
);

    logic en;

    // stage 1: products
    logic                 v1_reg;
    logic signed [31:0]   pxz_reg, pwy_reg, pwx_reg, pyz_reg;
    logic [30:0]          sxx_reg, syy_reg, szz_reg, sww_reg;
    logic [2:0][15:0]     acc1_reg;
    logic [gsq_pkg::SW-1:0] st1_reg;

    // stage 2: rotated vector and norm
    logic                 v2_reg;
    logic [2:0][gsq_pkg::MAGW-1:0] mag2_reg;
    logic [2:0]           neg2_reg;
    logic [gsq_pkg::NW-1:0] n2_reg;
    logic [2:0][15:0]     acc2_reg;
    logic [gsq_pkg::SW-1:0] st2_reg;

    // stage 3: scaled numerators
    logic                 v3_reg;
    gsq_pkg::job_t        job_reg;

    logic signed [31:0]   sxx_full, syy_full, szz_full, sww_full;
    logic signed [33:0]   rx, ry;
    logic signed [32:0]   rz;
    logic signed [33:0]   rz_ext;
    logic [2:0][gsq_pkg::MAGW-1:0] mag_next;
    logic [2:0]           neg_next;
    logic [gsq_pkg::NW-1:0] n_next;
    logic [2:0][gsq_pkg::NUMW-1:0] num_next;

    assign en        = !v3_reg || job_ready;
    assign in_ready  = en;
    assign job_valid = v3_reg;
    assign job       = job_reg;

    assign sxx_full = quat_x * quat_x;
    assign syy_full = quat_y * quat_y;
    assign szz_full = quat_z * quat_z;
    assign sww_full = quat_w * quat_w;

    always_comb
    begin
        rx = ({{2{pxz_reg[31]}}, pxz_reg} - {{2{pwy_reg[31]}}, pwy_reg}) <<< 1;
        ry = ({{2{pwx_reg[31]}}, pwx_reg} + {{2{pyz_reg[31]}}, pyz_reg}) <<< 1;
        rz = $signed({2'b00, sww_reg}) + $signed({2'b00, szz_reg})
           - $signed({2'b00, sxx_reg}) - $signed({2'b00, syy_reg});
        rz_ext = {rz[32], rz};
        neg_next[0] = rx[33];
        neg_next[1] = ry[33];
        neg_next[2] = rz_ext[33];
        mag_next[0] = rx[33] ? 33'(-rx) : rx[32:0];
        mag_next[1] = ry[33] ? 33'(-ry) : ry[32:0];
        mag_next[2] = rz_ext[33] ? 33'(-rz_ext) : rz_ext[32:0];
        n_next = {2'b00, sxx_reg} + {2'b00, syy_reg} + {2'b00, szz_reg}
               + {2'b00, sww_reg};
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = mag2_reg[i] * {{gsq_pkg::MAGW{1'b0}}, grav_mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxz_reg  <= quat_x * quat_z;
            pwy_reg  <= quat_w * quat_y;
            pwx_reg  <= quat_w * quat_x;
            pyz_reg  <= quat_y * quat_z;
            sxx_reg  <= sxx_full[30:0];
            syy_reg  <= syy_full[30:0];
            szz_reg  <= szz_full[30:0];
            sww_reg  <= sww_full[30:0];
            acc1_reg <= {accel_z, accel_y, accel_x};
            st1_reg  <= stamp_in;

            mag2_reg <= mag_next;
            neg2_reg <= neg_next;
            n2_reg   <= n_next;
            acc2_reg <= acc1_reg;
            st2_reg  <= st1_reg;

            job_reg.num   <= num_next;
            job_reg.neg   <= neg2_reg;
            job_reg.n     <= n2_reg;
            job_reg.accel <= acc2_reg;
            job_reg.stamp <= st2_reg;
        end
    end

endmodule

/* hdl/gsq_fifo.sv */
`timescale 1ns / 1ps

module gsq_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  gsq_pkg::job_t  push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output gsq_pkg::job_t  pop_data
);

    localparam int PW = $clog2(gsq_pkg::FIFO_DEPTH);

    gsq_pkg::job_t     mem_reg [gsq_pkg::FIFO_DEPTH];
    logic [PW-1:0]     wr_reg, rd_reg;
    logic [PW:0]       cnt_reg;
    logic              push, pop;

    assign push_ready = cnt_reg != (PW+1)'(gsq_pkg::FIFO_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

/* hdl/gsq_back.sv */
`timescale 1ns / 1ps

module gsq_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    output logic                    job_ready,
    input  gsq_pkg::job_t           job,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [15:0]      linear_x,
    output logic signed [15:0]      linear_y,
    output logic signed [15:0]      linear_z,
    output logic signed [15:0]      gravity_x,
    output logic signed [15:0]      gravity_y,
    output logic signed [15:0]      gravity_z,
    output logic [gsq_pkg::SW-1:0]  stamp_out,
    output logic                    zero_norm
);

    localparam int DW = gsq_pkg::NW + gsq_pkg::QUOW;

    gsq_pkg::back_st_t state_reg, state_next;
    logic [gsq_pkg::CNTW-1:0] cnt_reg, cnt_next;
    logic [2:0][gsq_pkg::REMW-1:0] rem_reg, rem_next;
    logic [2:0][gsq_pkg::QUOW-1:0] quo_reg, quo_next;
    logic [DW-1:0]            dsh_reg, dsh_next;
    logic [2:0]               neg_reg;
    logic                     zero_reg;
    logic [2:0][15:0]         acc_reg;
    logic [gsq_pkg::SW-1:0]   st_reg;
    logic                     out_valid_reg;

    logic                     load_out, pop, step;
    logic [2:0][15:0]         grav;
    logic [2:0][15:0]         lin;
    logic signed [16:0]       diff;

    assign out_valid = out_valid_reg;
    assign job_ready = pop;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        load_out   = 1'b0;
        step       = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            gsq_pkg::ST_IDLE:
            begin
                pop = job_valid;
                if (job_valid)
                begin
                    state_next = gsq_pkg::ST_DIV;
                    cnt_next   = '0;
                end
            end
            gsq_pkg::ST_DIV:
            begin
                step     = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == gsq_pkg::CNTW'(gsq_pkg::STEPS - 1))
                    state_next = gsq_pkg::ST_DONE;
            end
            gsq_pkg::ST_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
                if (load_out)
                begin
                    pop = job_valid;
                    cnt_next = '0;
                    state_next = job_valid ? gsq_pkg::ST_DIV : gsq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gsq_pkg::ST_IDLE;
            end
        endcase
    end

    // restoring division, three quotient bits per step in each lane
    always_comb
    begin
        logic [DW-1:0] d;
        rem_next = rem_reg;
        quo_next = quo_reg;
        d = dsh_reg;
        for (int j = 0; j < gsq_pkg::BITS_PER_STEP; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_next[i] >= {{(gsq_pkg::REMW-DW){1'b0}}, d})
                begin
                    rem_next[i] = rem_next[i] - {{(gsq_pkg::REMW-DW){1'b0}}, d};
                    quo_next[i] = {quo_next[i][gsq_pkg::QUOW-2:0], 1'b1};
                end
                else
                begin
                    quo_next[i] = {quo_next[i][gsq_pkg::QUOW-2:0], 1'b0};
                end
            end
            d = d >> 1;
        end
        dsh_next = d;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (zero_reg)
                grav[i] = '0;
            else if (neg_reg[i])
                grav[i] = 16'(-{4'b0000, quo_reg[i]});
            else
                grav[i] = {4'b0000, quo_reg[i]};
        end
        for (int i = 0; i < 3; i++)
        begin
            diff = $signed({acc_reg[i][15], acc_reg[i]}) - $signed({grav[i][15], grav[i]});
            if (diff > 17'sd32767)
                lin[i] = 16'h7FFF;
            else if (diff < -17'sd32768)
                lin[i] = 16'h8000;
            else
                lin[i] = diff[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gsq_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= {job.num[i], 1'b0}
                            + {{(gsq_pkg::REMW-gsq_pkg::NW){1'b0}}, job.n};
                quo_reg[i] <= '0;
            end
            dsh_reg  <= {job.n, {gsq_pkg::QUOW{1'b0}}};
            neg_reg  <= job.neg;
            zero_reg <= job.n == '0;
            acc_reg  <= job.accel;
            st_reg   <= job.stamp;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            dsh_reg <= dsh_next;
        end
        if (load_out)
        begin
            linear_x  <= lin[0];
            linear_y  <= lin[1];
            linear_z  <= lin[2];
            gravity_x <= grav[0];
            gravity_y <= grav[1];
            gravity_z <= grav[2];
            stamp_out <= st_reg;
            zero_norm <= zero_reg;
        end
    end

endmodule

/* tb/sv/gravity_split_from_quaternion_test.sv */
`timescale 1ns / 1ps

module gravity_split_from_quaternion_test;

    typedef struct {
        logic signed [15:0] qx, qy, qz, qw, ax, ay, az;
        logic [62:0]        stamp;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] lx, ly, lz, gx, gy, gz;
        logic [62:0]        stamp;
        logic               zn;
    } split_t;

    typedef struct {
        sample_t s;
        logic    typed;
        split_t  r;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [11:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
    logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
    logic [62:0] stamp_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] linear_x, linear_y, linear_z, gravity_x, gravity_y, gravity_z;
    logic [62:0] stamp_out;
    logic zero_norm;

    gravity_split_from_quaternion dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .stamp_in(stamp_in), .out_valid(out_valid), .out_ready(out_ready),
        .linear_x(linear_x), .linear_y(linear_y), .linear_z(linear_z),
        .gravity_x(gravity_x), .gravity_y(gravity_y), .gravity_z(gravity_z),
        .stamp_out(stamp_out), .zero_norm(zero_norm)
    );

    always #6 clk = ~clk;

    logic [11:0] grav_mag = gsq_pkg::GRAV_RESET;
    split_t expected_q[$];
    int mismatches = 0;
    int results_seen = 0;
    int zero_seen = 0;
    bit idle_free = 1'b0;
    bit hold_rx = 1'b0;
    bit stim_done = 1'b0;

    function automatic longint scale_axis(longint r, longint g, longint n);
        longint mag, quo;
        begin
            mag = (r < 0) ? -r : r;
            quo = (2 * mag * g + n) / (2 * n);
            return (r < 0) ? -quo : quo;
        end
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
        begin
            if (v > 32767)
                return 16'sd32767;
            if (v < -32768)
                return -16'sd32768;
            return v[15:0];
        end
    endfunction

    function automatic split_t predict_split(sample_t s, logic [11:0] g);
        longint qx, qy, qz, qw, n, rv[3], gv[3], av[3];
        split_t o;
        begin
            qx = s.qx; qy = s.qy; qz = s.qz; qw = s.qw;
            av[0] = s.ax; av[1] = s.ay; av[2] = s.az;
            rv[0] = 2 * (qx * qz - qw * qy);
            rv[1] = 2 * (qw * qx + qy * qz);
            rv[2] = qw * qw - qx * qx - qy * qy + qz * qz;
            n = qx * qx + qy * qy + qz * qz + qw * qw;
            for (int i = 0; i < 3; i++)
                gv[i] = (n == 0) ? 0 : scale_axis(rv[i], longint'(g), n);
            o.lx = sat16(av[0] - gv[0]);
            o.ly = sat16(av[1] - gv[1]);
            o.lz = sat16(av[2] - gv[2]);
            o.gx = gv[0][15:0];
            o.gy = gv[1][15:0];
            o.gz = gv[2][15:0];
            o.stamp = s.stamp;
            o.zn = (n == 0);
            return o;
        end
    endfunction

    task automatic send_sample(sample_t s, logic typed, split_t r);
        split_t p;
        begin
            if (!idle_free)
                while ($urandom_range(99) < 12)
                begin
                    in_valid <= 1'b0;
                    @(negedge clk);
                end
            quat_x <= s.qx; quat_y <= s.qy; quat_z <= s.qz; quat_w <= s.qw;
            accel_x <= s.ax; accel_y <= s.ay; accel_z <= s.az;
            stamp_in <= s.stamp;
            in_valid <= 1'b1;
            p = predict_split(s, grav_mag);
            if (typed && p != r)
                $display("directed row disagrees with predictor, stamp %0d", s.stamp);
            expected_q.push_back(typed ? r : p);
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic write_gravity(logic [11:0] v);
        begin
            in_valid <= 1'b0;
            while (expected_q.size() != 0)
                @(negedge clk);
            repeat (20) @(negedge clk);
            cfg_data <= v;
            cfg_we <= 1'b1;
            @(negedge clk);
            cfg_we <= 1'b0;
            grav_mag = v;
        end
    endtask

    function automatic sample_t rand_sample(int kind);
        sample_t s;
        logic signed [15:0] amp;
        begin
            s.stamp = 63'({$urandom, $urandom});
            s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
            if (kind < 60) begin
                amp = 16'($urandom_range(20000));
                s.qx = $signed(16'($urandom_range(2 * amp))) - amp;
                s.qy = $signed(16'($urandom_range(2 * amp))) - amp;
                s.qz = $signed(16'($urandom_range(2 * amp))) - amp;
                s.qw = $signed(16'($urandom_range(2 * amp))) - amp;
                s.ax = $signed(16'($urandom_range(8000))) - 16'sd4000;
            end else if (kind < 95) begin
                s.qx = 16'($urandom); s.qy = 16'($urandom);
                s.qz = 16'($urandom); s.qw = 16'($urandom);
            end else begin
                s.qx = '0; s.qy = '0; s.qz = '0; s.qw = '0;
                if (kind == 99)
                    s.qw = 16'($urandom_range(3));
            end
            return s;
        end
    endfunction

    row_t rows[$];

    function automatic row_t mk(int qx, int qy, int qz, int qw, int ax, int ay, int az,
                                longint st);
        row_t r;
        begin
            r.s.qx = 16'(qx); r.s.qy = 16'(qy); r.s.qz = 16'(qz); r.s.qw = 16'(qw);
            r.s.ax = 16'(ax); r.s.ay = 16'(ay); r.s.az = 16'(az); r.s.stamp = 63'(st);
            r.typed = 1'b0;
            r.r = '{default: 0};
            return r;
        end
    endfunction

    function automatic row_t typed_row(row_t r, int lx, int ly, int lz, int gx, int gy,
                                       int gz, logic zn);
        begin
            r.typed = 1'b1;
            r.r.lx = 16'(lx); r.r.ly = 16'(ly); r.r.lz = 16'(lz);
            r.r.gx = 16'(gx); r.r.gy = 16'(gy); r.r.gz = 16'(gz);
            r.r.stamp = r.s.stamp; r.r.zn = zn;
            return r;
        end
    endfunction

    initial begin
        sample_t s;
        split_t none;
        logic [11:0] mags[5];
        none = '{default: 0};
        mags = '{12'd0, 12'd4095, 12'd1, 12'd2510, 12'd1234};

        // zero quaternion: gravity 0, linear = accel
        rows.push_back(typed_row(mk(0, 0, 0, 0, 32767, -32768, 5, 0), 32767, -32768, 5,
                                 0, 0, 0, 1'b1));
        // identity: gravity (0,0,G)
        rows.push_back(typed_row(mk(0, 0, 0, 16384, 0, 0, 0, 63'h7FFF_FFFF_FFFF_FFFF),
                                 0, 0, -2510, 0, 0, 2510, 1'b0));
        rows.push_back(typed_row(mk(0, 0, 0, 1, -32768, 0, -32768, 1),
                                 -32768, 0, -32768, 0, 0, 2510, 1'b0));
        rows.push_back(typed_row(mk(0, 0, 0, -32768, 1, 2, 3, 2), 1, 2, 3 - 2510,
                                 0, 0, 2510, 1'b0));
        rows.push_back(typed_row(mk(16384, 0, 0, 0, 0, 0, 0, 3), 0, 0, 2510,
                                 0, 0, -2510, 1'b0));
        rows.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 4));
        rows.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 5));
        rows.push_back(mk(-32768, 32767, -32768, 32767, 0, -1, 1, 6));
        rows.push_back(mk(1, 0, 0, 0, 0, 0, 0, 7));
        rows.push_back(mk(0, 1, 0, 0, 0, 0, 0, 8));
        rows.push_back(mk(0, 0, 1, 0, 0, 0, 0, 9));
        rows.push_back(mk(11585, 0, 0, 11585, 100, 200, 300, 10));
        rows.push_back(mk(1, 1, 1, 1, -32768, 32767, 0, 11));
        rows.push_back(mk(3, -5, 7, 2, 0, 0, 0, 12));
        rows.push_back(mk(0, 11585, 0, 11585, -32768, -32768, -32768, 13));

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (rows[i])
            send_sample(rows[i].s, rows[i].typed, rows[i].r);

        foreach (mags[m]) begin
            write_gravity(mags[m]);
            if (m == 0) begin
                for (int k = 0; k < 4; k++)
                    send_sample(mk(0, 0, 0, 16384, -32768, 32767, -32768, k).s, 1'b0, none);
                write_gravity(12'd4095);
                send_sample(typed_row(mk(0, 0, 0, 16384, 0, 0, -32768, 77), 0, 0, -32768,
                                      0, 0, 4095, 1'b0).s, 1'b0, none);
                write_gravity(12'd0);
            end
            for (int k = 0; k < 320; k++) begin
                idle_free = (m == 2 && k >= 100 && k < 200);
                if (m == 3 && k == 50)
                    hold_rx = 1'b1;
                s = rand_sample($urandom_range(99));
                send_sample(s, 1'b0, none);
            end
            idle_free = 1'b0;
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (hold_rx);
        repeat (300) @(negedge clk);
        hold_rx = 1'b0;
    end

    always @(negedge clk)
        out_ready <= !hold_rx && (idle_free || $urandom_range(99) >= 12);

    always @(posedge clk) begin
        split_t a, e;
        if (rst_n && out_valid && out_ready) begin
            a.lx = linear_x; a.ly = linear_y; a.lz = linear_z;
            a.gx = gravity_x; a.gy = gravity_y; a.gz = gravity_z;
            a.stamp = stamp_out; a.zn = zero_norm;
            results_seen++;
            if (zero_norm)
                zero_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer stamp %0d", stamp_out);
            end else begin
                e = expected_q.pop_front();
                if (a != e) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp lin %0d %0d %0d grav %0d %0d %0d st %0d z %0d",
                                 e.lx, e.ly, e.lz, e.gx, e.gy, e.gz, e.stamp, e.zn);
                        $display("         got lin %0d %0d %0d grav %0d %0d %0d st %0d z %0d",
                                 a.lx, a.ly, a.lz, a.gx, a.gy, a.gz, a.stamp, a.zn);
                    end
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("checked %0d transfers (%0d zero-norm) over 7 gravity settings",
                 results_seen, zero_seen);
        $display("gravity range covered from 0 to 4095, with a long output stall");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("gravity_split_from_quaternion_test OK");
        else
            $display("gravity_split_from_quaternion_test NOT OK");
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("gravity_split_from_quaternion_test NOT OK");
        $finish;
    end

endmodule
